// ===== rtl/core/lsqu_pkg.sv =====
// Shared types, constants and saturation helper for the Lyapunov spectrum
// QR update unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lsqu_pkg;

    // Fixed-point format and datapath widths
    localparam int FRAC   = 24;
    localparam int TS_W   = 31;
    localparam int EL_W   = 48;
    localparam int ACC_W  = 48;
    localparam int DEN_W  = EL_W + 1;
    localparam int NUM_W  = 58;
    localparam int REM_W  = NUM_W + FRAC;

    localparam logic [TS_W-1:0]   TS_RESET = 31'd167772;
    localparam logic signed [31:0] Q_ONE   = 32'sh0100_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] LN2_Q30 = 32'sd744261118;
    localparam logic [63:0]        SQ_BIT0 = 64'h4000_0000_0000_0000;

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE,
        S_MM_RD, S_MM_MUL, S_MM_ACC,
        S_CP_RD, S_CP_WR,
        S_GS_RD, S_GS_M1, S_GS_M2, S_GS_ACC, S_GS_DS, S_GS_DW,
        S_GS_URI, S_GS_UMUL, S_GS_USUB,
        S_NM_RD, S_NM_MUL, S_NM_ACC, S_NM_SQ, S_NM_DRD, S_NM_DST, S_NM_DW,
        S_EX_LN0, S_LN_NRM, S_LN_SQ1, S_LN_SQ2, S_LN_MUL, S_LN_FIN,
        S_EX_M1, S_EX_M2, S_EX_M3, S_EX_ST, S_EX_DW,
        S_OUT
    } t_state;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] f_sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'(S32_MAX)) begin
            res = S32_MAX;
        end else if (v < 64'(S32_MIN)) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lyapunov_spectrum_qr_update_unit.sv =====
// Lyapunov spectrum update: Jacobian times basis, Gram-Schmidt, norms, exponents.
// Depends on lsqu_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one Jacobian element per request,
//   row-major, DIM*DIM requests per time step. The first DIM*DIM-1 requests of a
//   step are taken one per cycle. The last one starts the update; o_stall stays
//   high until all DIM results have been loaded into the output register.
//   Output channel (o_valid / i_stall) delivers DIM requests, exponent index 0
//   first, o_last on index DIM-1, each carrying the new elapsed time.
//   The update runs on one shared 32x32 multiplier, a restoring divider,
//   a 32-step square root and a 24-squaring log loop.
//   A stalled receiver holds the output register; the unit waits before
//   loading the next result, and after the last one accepts new elements
//   while that result is still pending.
//   Reset (synchronous, active low) restores an identity basis, zero
//   exponents, zero elapsed time and the default time step. i_cfg_we writes
//   the time step; write it only while no step is in progress.
`timescale 1ns / 1ps
`default_nettype none

module lyapunov_spectrum_qr_update_unit #(
    parameter int DIM = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [30:0]          i_cfg_wdata,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire signed [31:0]   i_jac_value,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic signed [31:0]  o_exponent,
    output logic [2:0]          o_exponent_index,
    output logic                o_last,
    output logic [47:0]         o_elapsed_time
);

    localparam int NE = DIM * DIM;
    localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW = (NE > 1) ? $clog2(NE) : 1;
    localparam int ACC_W = lsqu_pkg::ACC_W;
    localparam int NUM_W = lsqu_pkg::NUM_W;
    localparam int DEN_W = lsqu_pkg::DEN_W;
    localparam int REM_W = lsqu_pkg::REM_W;
    localparam int EL_W  = lsqu_pkg::EL_W;
    localparam int FRAC  = lsqu_pkg::FRAC;

    function automatic logic [AW-1:0] f_addr(input logic [IW-1:0] row,
                                             input logic [IW-1:0] col);
        return AW'(int'(row) * DIM + int'(col));
    endfunction

    // Control and datapath registers
    lsqu_pkg::t_state r_state, n_state;
    logic [AW-1:0]              r_cnt;
    logic [AW-1:0]              r_a;
    logic [IW-1:0]              r_i, r_j, r_k, r_c;
    logic                       r_bas_init;
    logic [lsqu_pkg::TS_W-1:0]  r_tstep;
    logic [EL_W-1:0]            r_elapsed;
    logic signed [31:0]         r_exp [DIM];
    logic signed [31:0]         r_norm [DIM];
    logic signed [ACC_W-1:0]    r_acc, r_ab;
    logic signed [63:0]         r_prod;
    logic signed [NUM_W-1:0]    r_num;
    logic signed [31:0]         r_ln;
    logic [30:0]                r_lm;
    logic [4:0]                 r_lp;
    logic [4:0]                 r_lk;
    logic [FRAC-1:0]            r_frac;
    logic [63:0]                r_sx, r_sres, r_sbit;

    // Memories
    logic signed [31:0] r_jac_mem [NE];
    logic signed [31:0] r_bas_mem [NE];
    logic signed [31:0] r_prd_mem [NE];
    logic signed [31:0] r_jac_q, r_bas_q, r_prd_q;

    // Output register
    logic                r_o_valid;
    logic signed [31:0]  r_o_exp;
    logic [2:0]          r_o_idx;
    logic                r_o_last;
    logic [EL_W-1:0]     r_o_el;

    // Divider
    logic                    r_dv_busy, r_dv_done, r_dv_neg;
    logic [4:0]              r_dv_cnt;
    logic [REM_W-1:0]        r_rem, r_dsr;
    logic [29:0]             r_dq;
    logic signed [31:0]      r_dv_res;

    // Control decode
    logic               in_acc, out_load;
    logic [AW-1:0]      jac_ra, bas_ra, bas_wa, prd_ra, prd_wa;
    logic               bas_we, prd_we;
    logic signed [31:0] bas_wd, prd_wd;
    logic signed [31:0] mul_a, mul_b;
    logic               dv_start;
    logic signed [NUM_W-1:0] dv_num;
    logic [DEN_W-1:0]   dv_den;

    // Derived values
    logic signed [63:0]      w_prod;
    logic signed [ACC_W-1:0] w_qm, w_acc_sum;
    logic                    k_last, j_last, i_last, c_last, a_last, gi_last;
    logic                    sq_big;
    logic [DEN_W-1:0]        w_den_u;
    logic signed [7:0]       w_lexp;
    logic [31:0]             w_lt;
    logic [63:0]             w_strial, w_sres_n;
    logic                    w_sge;

    assign w_prod    = mul_a * mul_b;
    assign w_qm      = ACC_W'(r_prod >>> FRAC);
    assign w_acc_sum = r_acc + w_qm;
    assign k_last    = (r_k == IW'(DIM - 1));
    assign j_last    = (r_j == IW'(DIM - 1));
    assign i_last    = (r_i == IW'(DIM - 1));
    assign c_last    = (r_c == IW'(DIM - 1));
    assign a_last    = (r_a == AW'(NE - 1));
    assign gi_last   = (r_i == r_c - IW'(1));
    assign sq_big    = |w_acc_sum[ACC_W-1:38];
    assign w_den_u   = {1'b0, r_elapsed} + DEN_W'(r_tstep);
    assign w_lexp    = $signed({3'b000, r_lp}) - 8'sd24;
    assign w_lt      = r_prod[61:30];
    assign w_strial  = r_sres + r_sbit;
    assign w_sge     = (r_sx >= w_strial);
    assign w_sres_n  = w_sge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);

    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == lsqu_pkg::S_OUT) && (!r_o_valid || !i_stall);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsqu_pkg::S_IDLE:    if (in_acc && r_cnt == AW'(NE - 1)) n_state = lsqu_pkg::S_MM_RD;
            lsqu_pkg::S_MM_RD:   n_state = lsqu_pkg::S_MM_MUL;
            lsqu_pkg::S_MM_MUL:  n_state = lsqu_pkg::S_MM_ACC;
            lsqu_pkg::S_MM_ACC: begin
                if (k_last && j_last && i_last) n_state = lsqu_pkg::S_CP_RD;
                else n_state = lsqu_pkg::S_MM_RD;
            end
            lsqu_pkg::S_CP_RD:   n_state = lsqu_pkg::S_CP_WR;
            lsqu_pkg::S_CP_WR: begin
                if (!a_last) n_state = lsqu_pkg::S_CP_RD;
                else if (DIM > 1) n_state = lsqu_pkg::S_GS_RD;
                else n_state = lsqu_pkg::S_NM_RD;
            end
            lsqu_pkg::S_GS_RD:   n_state = lsqu_pkg::S_GS_M1;
            lsqu_pkg::S_GS_M1:   n_state = lsqu_pkg::S_GS_M2;
            lsqu_pkg::S_GS_M2:   n_state = lsqu_pkg::S_GS_ACC;
            lsqu_pkg::S_GS_ACC:  n_state = j_last ? lsqu_pkg::S_GS_DS : lsqu_pkg::S_GS_RD;
            lsqu_pkg::S_GS_DS:   n_state = lsqu_pkg::S_GS_DW;
            lsqu_pkg::S_GS_DW:   if (r_dv_done) n_state = lsqu_pkg::S_GS_URI;
            lsqu_pkg::S_GS_URI:  n_state = lsqu_pkg::S_GS_UMUL;
            lsqu_pkg::S_GS_UMUL: n_state = lsqu_pkg::S_GS_USUB;
            lsqu_pkg::S_GS_USUB: begin
                if (!j_last) n_state = lsqu_pkg::S_GS_URI;
                else if (gi_last && c_last) n_state = lsqu_pkg::S_NM_RD;
                else n_state = lsqu_pkg::S_GS_RD;
            end
            lsqu_pkg::S_NM_RD:   n_state = lsqu_pkg::S_NM_MUL;
            lsqu_pkg::S_NM_MUL:  n_state = lsqu_pkg::S_NM_ACC;
            lsqu_pkg::S_NM_ACC: begin
                if (!j_last) n_state = lsqu_pkg::S_NM_RD;
                else if (sq_big) n_state = lsqu_pkg::S_NM_DRD;
                else n_state = lsqu_pkg::S_NM_SQ;
            end
            lsqu_pkg::S_NM_SQ:   if (r_sbit == 64'd1) n_state = lsqu_pkg::S_NM_DRD;
            lsqu_pkg::S_NM_DRD:  n_state = lsqu_pkg::S_NM_DST;
            lsqu_pkg::S_NM_DST:  n_state = lsqu_pkg::S_NM_DW;
            lsqu_pkg::S_NM_DW: begin
                if (r_dv_done) begin
                    if (!j_last) n_state = lsqu_pkg::S_NM_DRD;
                    else if (c_last) n_state = lsqu_pkg::S_EX_LN0;
                    else n_state = lsqu_pkg::S_NM_RD;
                end
            end
            lsqu_pkg::S_EX_LN0:
                n_state = (r_norm[r_c] == '0) ? lsqu_pkg::S_EX_M1 : lsqu_pkg::S_LN_NRM;
            lsqu_pkg::S_LN_NRM:  if (r_lm[30]) n_state = lsqu_pkg::S_LN_SQ1;
            lsqu_pkg::S_LN_SQ1:  n_state = lsqu_pkg::S_LN_SQ2;
            lsqu_pkg::S_LN_SQ2:
                n_state = (r_lk == 5'(FRAC - 1)) ? lsqu_pkg::S_LN_MUL : lsqu_pkg::S_LN_SQ1;
            lsqu_pkg::S_LN_MUL:  n_state = lsqu_pkg::S_LN_FIN;
            lsqu_pkg::S_LN_FIN:  n_state = lsqu_pkg::S_EX_M1;
            lsqu_pkg::S_EX_M1:   n_state = lsqu_pkg::S_EX_M2;
            lsqu_pkg::S_EX_M2:   n_state = lsqu_pkg::S_EX_M3;
            lsqu_pkg::S_EX_M3:   n_state = lsqu_pkg::S_EX_ST;
            lsqu_pkg::S_EX_ST:   n_state = lsqu_pkg::S_EX_DW;
            lsqu_pkg::S_EX_DW: begin
                if (r_dv_done) n_state = c_last ? lsqu_pkg::S_OUT : lsqu_pkg::S_EX_LN0;
            end
            lsqu_pkg::S_OUT:     if (out_load && c_last) n_state = lsqu_pkg::S_IDLE;
            default:             n_state = lsqu_pkg::S_IDLE;
        endcase
    end

    // Memory ports, multiplier operands and divider start
    always_comb begin
        jac_ra   = f_addr(r_i, r_k);
        bas_ra   = '0;
        bas_we   = 1'b0;
        bas_wa   = f_addr(r_j, r_c);
        bas_wd   = r_dv_res;
        prd_ra   = f_addr(r_j, r_c);
        prd_we   = 1'b0;
        prd_wa   = f_addr(r_i, r_j);
        prd_wd   = lsqu_pkg::f_sat32(64'(w_acc_sum));
        mul_a    = '0;
        mul_b    = '0;
        dv_start = 1'b0;
        dv_num   = NUM_W'(r_ab);
        dv_den   = DEN_W'(r_acc);
        unique case (r_state)
            lsqu_pkg::S_MM_RD: begin
                bas_ra = f_addr(r_k, r_j);
            end
            lsqu_pkg::S_MM_MUL: begin
                bas_ra = f_addr(r_k, r_j);
                mul_a  = r_jac_q;
                if (r_bas_init) mul_b = r_bas_q;
                else mul_b = (r_k == r_j) ? lsqu_pkg::Q_ONE : '0;
            end
            lsqu_pkg::S_MM_ACC: begin
                prd_we = k_last;
            end
            lsqu_pkg::S_CP_RD: begin
                prd_ra = r_a;
            end
            lsqu_pkg::S_CP_WR: begin
                prd_ra = r_a;
                bas_we = 1'b1;
                bas_wa = r_a;
                bas_wd = r_prd_q;
            end
            lsqu_pkg::S_GS_RD, lsqu_pkg::S_GS_ACC: begin
                bas_ra = f_addr(r_j, r_i);
            end
            lsqu_pkg::S_GS_M1: begin
                bas_ra = f_addr(r_j, r_i);
                mul_a  = r_bas_q;
                mul_b  = r_bas_q;
            end
            lsqu_pkg::S_GS_M2: begin
                bas_ra = f_addr(r_j, r_i);
                mul_a  = r_bas_q;
                mul_b  = r_prd_q;
            end
            lsqu_pkg::S_GS_DS: begin
                dv_start = 1'b1;
            end
            lsqu_pkg::S_GS_URI: begin
                bas_ra = f_addr(r_j, r_i);
            end
            lsqu_pkg::S_GS_UMUL: begin
                bas_ra = f_addr(r_j, r_c);
                mul_a  = r_dv_res;
                mul_b  = r_bas_q;
            end
            lsqu_pkg::S_GS_USUB: begin
                bas_ra = f_addr(r_j, r_c);
                bas_we = 1'b1;
                bas_wd = lsqu_pkg::f_sat32(64'(r_bas_q) - 64'(w_qm));
            end
            lsqu_pkg::S_NM_RD, lsqu_pkg::S_NM_ACC, lsqu_pkg::S_NM_DRD: begin
                bas_ra = f_addr(r_j, r_c);
            end
            lsqu_pkg::S_NM_MUL: begin
                bas_ra = f_addr(r_j, r_c);
                mul_a  = r_bas_q;
                mul_b  = r_bas_q;
            end
            lsqu_pkg::S_NM_DST: begin
                bas_ra   = f_addr(r_j, r_c);
                dv_start = 1'b1;
                dv_num   = NUM_W'(r_bas_q);
                dv_den   = DEN_W'(unsigned'(r_norm[r_c]));
            end
            lsqu_pkg::S_NM_DW: begin
                bas_ra = f_addr(r_j, r_c);
                bas_we = r_dv_done;
            end
            lsqu_pkg::S_LN_SQ1: begin
                mul_a = {1'b0, r_lm};
                mul_b = {1'b0, r_lm};
            end
            lsqu_pkg::S_LN_MUL: begin
                mul_a = {w_lexp, r_frac};
                mul_b = lsqu_pkg::LN2_Q30;
            end
            lsqu_pkg::S_EX_M1: begin
                mul_a = r_exp[r_c];
                mul_b = {8'b0, r_elapsed[EL_W-1:FRAC]};
            end
            lsqu_pkg::S_EX_M2: begin
                mul_a = r_exp[r_c];
                mul_b = {8'b0, r_elapsed[FRAC-1:0]};
            end
            lsqu_pkg::S_EX_ST: begin
                dv_start = 1'b1;
                dv_num   = r_num;
                dv_den   = w_den_u;
            end
            default: begin
            end
        endcase
    end

    // Memories: one write and one registered read per cycle each
    always_ff @(posedge i_clk) begin
        if (in_acc) r_jac_mem[r_cnt] <= i_jac_value;
        r_jac_q <= r_jac_mem[jac_ra];
    end

    always_ff @(posedge i_clk) begin
        if (bas_we) r_bas_mem[bas_wa] <= bas_wd;
        r_bas_q <= r_bas_mem[bas_ra];
    end

    always_ff @(posedge i_clk) begin
        if (prd_we) r_prd_mem[prd_wa] <= prd_wd;
        r_prd_q <= r_prd_mem[prd_ra];
    end

    // Control state, exponents, elapsed time, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lsqu_pkg::S_IDLE;
            r_cnt      <= '0;
            r_bas_init <= 1'b0;
            r_tstep    <= lsqu_pkg::TS_RESET;
            r_elapsed  <= '0;
            r_o_valid  <= 1'b0;
            for (int n = 0; n < DIM; n++) r_exp[n] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_tstep <= i_cfg_wdata;
            if (in_acc) begin
                r_cnt <= (r_cnt == AW'(NE - 1)) ? '0 : r_cnt + AW'(1);
            end
            if (r_state == lsqu_pkg::S_CP_WR && a_last) r_bas_init <= 1'b1;
            if (r_state == lsqu_pkg::S_EX_DW && r_dv_done) begin
                r_exp[r_c] <= r_dv_res;
                if (c_last) begin
                    r_elapsed <= w_den_u[EL_W] ? '1 : w_den_u[EL_W-1:0];
                end
            end
            if (out_load) r_o_valid <= 1'b1;
            else if (!i_stall) r_o_valid <= 1'b0;
        end
    end

    // Datapath: indices, accumulators, sqrt and log iterations, output payload
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (r_state)
            lsqu_pkg::S_IDLE: begin
                r_i   <= '0;
                r_j   <= '0;
                r_k   <= '0;
                r_a   <= '0;
                r_acc <= '0;
            end
            lsqu_pkg::S_MM_ACC: begin
                if (k_last) begin
                    r_acc <= '0;
                    r_k   <= '0;
                    if (j_last) begin
                        r_j <= '0;
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end else begin
                    r_acc <= w_acc_sum;
                    r_k   <= r_k + IW'(1);
                end
            end
            lsqu_pkg::S_CP_WR: begin
                r_a   <= r_a + AW'(1);
                r_c   <= (DIM > 1) ? IW'(1) : '0;
                r_i   <= '0;
                r_j   <= '0;
                r_acc <= '0;
                r_ab  <= '0;
            end
            lsqu_pkg::S_GS_M2: begin
                r_acc <= w_acc_sum;
            end
            lsqu_pkg::S_GS_ACC: begin
                r_ab <= r_ab + w_qm;
                r_j  <= j_last ? '0 : r_j + IW'(1);
            end
            lsqu_pkg::S_GS_USUB: begin
                if (j_last) begin
                    r_j   <= '0;
                    r_acc <= '0;
                    r_ab  <= '0;
                    if (gi_last) begin
                        r_i <= '0;
                        r_c <= c_last ? '0 : r_c + IW'(1);
                    end else begin
                        r_i <= r_i + IW'(1);
                    end
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            lsqu_pkg::S_NM_ACC: begin
                if (j_last) begin
                    r_j    <= '0;
                    r_acc  <= '0;
                    r_sx   <= 64'(unsigned'(w_acc_sum)) << FRAC;
                    r_sres <= '0;
                    r_sbit <= lsqu_pkg::SQ_BIT0;
                    if (sq_big) r_norm[r_c] <= lsqu_pkg::S32_MAX;
                end else begin
                    r_j   <= r_j + IW'(1);
                    r_acc <= w_acc_sum;
                end
            end
            lsqu_pkg::S_NM_SQ: begin
                if (w_sge) r_sx <= r_sx - w_strial;
                r_sres <= w_sres_n;
                r_sbit <= r_sbit >> 2;
                if (r_sbit == 64'd1) r_norm[r_c] <= w_sres_n[31:0];
            end
            lsqu_pkg::S_NM_DW: begin
                if (r_dv_done) begin
                    if (j_last) begin
                        r_j <= '0;
                        r_c <= c_last ? '0 : r_c + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
            end
            lsqu_pkg::S_EX_LN0: begin
                r_lm   <= r_norm[r_c][30:0];
                r_lp   <= 5'd30;
                r_lk   <= '0;
                r_frac <= '0;
                r_ln   <= lsqu_pkg::S32_MIN;
            end
            lsqu_pkg::S_LN_NRM: begin
                if (!r_lm[30]) begin
                    r_lm <= {r_lm[29:0], 1'b0};
                    r_lp <= r_lp - 5'd1;
                end
            end
            lsqu_pkg::S_LN_SQ2: begin
                r_lk <= r_lk + 5'd1;
                if (w_lt[31]) begin
                    r_lm   <= w_lt[31:1];
                    r_frac <= {r_frac[FRAC-2:0], 1'b1};
                end else begin
                    r_lm   <= w_lt[30:0];
                    r_frac <= {r_frac[FRAC-2:0], 1'b0};
                end
            end
            lsqu_pkg::S_LN_FIN: begin
                r_ln <= lsqu_pkg::f_sat32(r_prod >>> 30);
            end
            lsqu_pkg::S_EX_M2: begin
                r_num <= NUM_W'(r_prod);
            end
            lsqu_pkg::S_EX_M3: begin
                r_num <= r_num + NUM_W'(r_prod >>> FRAC) + NUM_W'(r_ln);
            end
            lsqu_pkg::S_EX_DW: begin
                if (r_dv_done) r_c <= c_last ? '0 : r_c + IW'(1);
            end
            lsqu_pkg::S_OUT: begin
                if (out_load) begin
                    r_o_exp  <= r_exp[r_c];
                    r_o_idx  <= 3'(r_c);
                    r_o_last <= c_last;
                    r_o_el   <= r_elapsed;
                    r_c      <= c_last ? '0 : r_c + IW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // Restoring divider: quotient of num*2^24/den, one bit a cycle, saturated
    logic                   dv_neg_in, dv_ovf, dv_ge;
    logic [NUM_W-1:0]       dv_un;
    logic [30:0]            dv_qn;

    assign dv_neg_in = dv_num[NUM_W-1];
    assign dv_un     = dv_neg_in ? unsigned'(-dv_num) : unsigned'(dv_num);
    assign dv_ovf    = (64'(dv_un) >= (64'(dv_den) << 7));
    assign dv_ge     = (r_rem >= r_dsr);
    assign dv_qn     = {r_dq, dv_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_done <= 1'b0;
        end else begin
            r_dv_done <= 1'b0;
            if (dv_start) begin
                if (dv_den == '0 || dv_ovf) begin
                    r_dv_done <= 1'b1;
                end else begin
                    r_dv_busy <= 1'b1;
                end
            end else if (r_dv_busy && r_dv_cnt == 5'd30) begin
                r_dv_busy <= 1'b0;
                r_dv_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_start) begin
            r_dv_neg <= dv_neg_in;
            r_rem    <= REM_W'(dv_un) << FRAC;
            r_dsr    <= REM_W'(dv_den) << 30;
            r_dq     <= '0;
            r_dv_cnt <= '0;
            r_dv_res <= dv_neg_in ? lsqu_pkg::S32_MIN : lsqu_pkg::S32_MAX;
        end else if (r_dv_busy) begin
            if (dv_ge) r_rem <= r_rem - r_dsr;
            r_dsr    <= r_dsr >> 1;
            r_dq     <= dv_qn[29:0];
            r_dv_cnt <= r_dv_cnt + 5'd1;
            if (r_dv_cnt == 5'd30) begin
                r_dv_res <= r_dv_neg ? -signed'({1'b0, dv_qn}) : signed'({1'b0, dv_qn});
            end
        end
    end

    // Ports
    assign o_stall          = (r_state != lsqu_pkg::S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_exponent       = r_o_exp;
    assign o_exponent_index = r_o_idx;
    assign o_last           = r_o_last;
    assign o_elapsed_time   = r_o_el;

    // Divider completes only while the sequencer waits for it
    a_dv_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_done |-> (r_state == lsqu_pkg::S_GS_DW || r_state == lsqu_pkg::S_NM_DW ||
                       r_state == lsqu_pkg::S_EX_DW))
        else $error("divider result with no consumer");

    // Element count is back at zero for the whole update
    a_cnt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lsqu_pkg::S_IDLE) |-> (r_cnt == '0))
        else $error("element count moved during update");

    // Square root bit stays a single one
    a_sq_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsqu_pkg::S_NM_SQ) |-> $onehot(r_sbit))
        else $error("square root bit lost");

    // A new result is loaded only from the output state
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == lsqu_pkg::S_OUT))
        else $error("output loaded outside output state");

    // Elapsed time never decreases
    a_elapsed_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_elapsed >= $past(r_elapsed)))
        else $error("elapsed time decreased");

endmodule

`default_nettype wire

// ===== verif/lyapunov_spectrum_qr_update_unit_test.sv =====
// Testbench for the Lyapunov spectrum QR update unit: streams Jacobian matrices,
// predicts exponents with a bit-exact fixed-point model and checks every result.
// Depends on lsqu_pkg and lyapunov_spectrum_qr_update_unit.
`timescale 1ns / 1ps

module lyapunov_spectrum_qr_update_unit_test;

    localparam int DIM = 4;
    localparam int NEL = DIM * DIM;
    localparam longint unsigned EL_MAX = (64'd1 << 48) - 1;
    localparam longint LN2_C = 64'd744261118;

    typedef struct {
        logic signed [31:0] exponent;
        logic [2:0]         index;
        logic               last;
        logic [47:0]        elapsed;
    } t_spectrum_entry;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [30:0] i_cfg_wdata = '0;
    logic i_valid = 1'b0;
    logic signed [31:0] i_jac_value = '0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_last;
    logic signed [31:0] o_exponent;
    logic [2:0] o_exponent_index;
    logic [47:0] o_elapsed_time;

    lyapunov_spectrum_qr_update_unit #(.DIM(DIM)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall), .i_jac_value(i_jac_value),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_exponent(o_exponent), .o_exponent_index(o_exponent_index),
        .o_last(o_last), .o_elapsed_time(o_elapsed_time)
    );

    // Clock: 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state
    logic signed [31:0] pr_basis [NEL];
    logic signed [31:0] pr_expo [DIM];
    logic signed [31:0] pr_jac [NEL];
    longint unsigned    pr_elapsed;
    int                 pr_count;
    logic [30:0]        pr_step;

    logic signed [31:0] jac_q [$];
    t_spectrum_entry    spectrum_q [$];
    int n_pushed = 0;
    int n_taken = 0;
    int n_errors = 0;
    bit idle_en = 1'b1;
    bit req_taken = 1'b0;
    int in_gap = 0;
    int out_gap = 0;

    function automatic longint fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        return (longint'(a) * longint'(b)) >>> 24;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return lsqu_pkg::S32_MAX;
        if (v < -64'sd2147483648) return lsqu_pkg::S32_MIN;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_div(longint n, longint d);
        bit neg;
        longint unsigned un, ud, q, r;
        neg = (n < 0) != (d < 0);
        if (d == 0) return (n < 0) ? lsqu_pkg::S32_MIN : lsqu_pkg::S32_MAX;
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = un / ud;
        r = un % ud;
        if (q >= (64'd1 << 31)) return neg ? lsqu_pkg::S32_MIN : lsqu_pkg::S32_MAX;
        for (int k = 0; k < 24; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 64'd1;
            end
        end
        if (!neg) return (q > 64'd2147483647) ? lsqu_pkg::S32_MAX : q[31:0];
        if (q >= (64'd1 << 31)) return lsqu_pkg::S32_MIN;
        return 32'(-longint'(q));
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] fx_ln(logic signed [31:0] x);
        int p;
        longint unsigned m;
        longint frac, l2;
        if (x <= 0) return lsqu_pkg::S32_MIN;
        p = 30;
        while (p > 0 && x[p] == 1'b0) p--;
        m = longint'(x) << (30 - p);
        frac = 0;
        for (int k = 0; k < 24; k++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        l2 = longint'(p - 24) * (64'sd1 << 24) + frac;
        return clamp32((l2 * LN2_C) >>> 30);
    endfunction

    // Advance the predictor by one Jacobian element; push results on the last one
    function automatic void predict_element(logic signed [31:0] v);
        logic signed [31:0] prod [NEL];
        logic signed [31:0] norms [DIM];
        longint acc, beta, ab, sq, old, num;
        longint unsigned eh, el, den;
        logic signed [31:0] coef;
        t_spectrum_entry e;
        if (pr_count >= NEL) pr_count = 0;
        pr_jac[pr_count] = v;
        pr_count++;
        if (pr_count < NEL) return;
        pr_count = 0;
        // Multiply Jacobian by basis
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                acc = 0;
                for (int k = 0; k < DIM; k++)
                    acc += fx_mul(pr_jac[i*DIM+k], pr_basis[k*DIM+j]);
                prod[i*DIM+j] = clamp32(acc);
            end
        end
        pr_basis = prod;
        // Classical Gram-Schmidt against the raw product columns
        for (int c = 0; c < DIM; c++) begin
            for (int i = 0; i < c; i++) begin
                beta = 0;
                ab = 0;
                for (int j = 0; j < DIM; j++) begin
                    beta += fx_mul(pr_basis[j*DIM+i], pr_basis[j*DIM+i]);
                    ab += fx_mul(pr_basis[j*DIM+i], prod[j*DIM+c]);
                end
                coef = fx_div(ab, beta);
                for (int j = 0; j < DIM; j++)
                    pr_basis[j*DIM+c] = clamp32(longint'(pr_basis[j*DIM+c])
                                        - fx_mul(coef, pr_basis[j*DIM+i]));
            end
        end
        // Normalize columns
        for (int c = 0; c < DIM; c++) begin
            sq = 0;
            for (int j = 0; j < DIM; j++)
                sq += fx_mul(pr_basis[j*DIM+c], pr_basis[j*DIM+c]);
            if (sq >= (64'sd1 << 38)) norms[c] = lsqu_pkg::S32_MAX;
            else norms[c] = 32'(int_sqrt(longint'(sq) << 24));
            for (int j = 0; j < DIM; j++)
                pr_basis[j*DIM+c] = fx_div(pr_basis[j*DIM+c], norms[c]);
        end
        // Running average of log growth
        eh = pr_elapsed >> 24;
        el = pr_elapsed & ((64'd1 << 24) - 1);
        den = pr_elapsed + pr_step;
        for (int c = 0; c < DIM; c++) begin
            old = pr_expo[c];
            num = old * longint'(eh) + ((old * longint'(el)) >>> 24) + fx_ln(norms[c]);
            pr_expo[c] = fx_div(num, longint'(den));
        end
        pr_elapsed = (den > EL_MAX) ? EL_MAX : den;
        for (int c = 0; c < DIM; c++) begin
            e.exponent = pr_expo[c];
            e.index = 3'(c);
            e.last = (c == DIM - 1);
            e.elapsed = pr_elapsed[47:0];
            spectrum_q.push_back(e);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Capture accepted requests and predict
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_element(i_jac_value);
            n_taken++;
            req_taken = 1'b1;
        end
    end

    // Driver: hold a stalled request, else insert a gap or present the next one
    always @(negedge i_clk) begin
        if (i_valid && !req_taken) begin
            // hold
        end else if (in_gap > 0) begin
            in_gap--;
            i_valid <= 1'b0;
        end else if (jac_q.size() != 0) begin
            i_jac_value <= jac_q.pop_front();
            i_valid <= 1'b1;
            in_gap = pick_gap();
        end else begin
            i_valid <= 1'b0;
        end
        req_taken = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (out_gap > 0) begin
            out_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            out_gap = pick_gap();
        end
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_spectrum_entry e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (spectrum_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("ERROR: unexpected result exp=%h idx=%0d", o_exponent,
                             o_exponent_index);
            end else begin
                e = spectrum_q.pop_front();
                if (o_exponent !== e.exponent || o_exponent_index !== e.index
                        || o_last !== e.last || o_elapsed_time !== e.elapsed) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: exp %h/%h idx %0d/%0d last %b/%b el %h/%h",
                                 e.exponent, o_exponent, e.index, o_exponent_index,
                                 e.last, o_last, e.elapsed, o_elapsed_time);
                end
            end
        end
    end

    task automatic push_jac(logic signed [31:0] v);
        jac_q.push_back(v);
        n_pushed++;
    endtask

    task automatic wait_drained();
        wait (n_taken == n_pushed && spectrum_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_step(logic [30:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pr_step = v;
    endtask

    // One random matrix; mostly moderate entries, sometimes degenerate or wild
    task automatic push_random_matrix();
        int mode, zc;
        logic signed [31:0] v;
        mode = $urandom_range(0, 9);
        zc = $urandom_range(0, DIM - 1);
        for (int k = 0; k < NEL; k++) begin
            if (mode < 5) v = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
            else if (mode < 7) v = ((k % (DIM + 1)) == 0)
                                 ? lsqu_pkg::Q_ONE + $urandom_range(0, 32'h00FF_FFFF)
                                 : $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            else if (mode < 9) v = ((k % DIM) == zc) ? 32'sd0
                                 : $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            else v = $urandom;
            push_jac(v);
        end
    endtask

    initial begin
        logic [30:0] ts;
        pr_elapsed = 0;
        pr_count = 0;
        pr_step = lsqu_pkg::TS_RESET;
        for (int k = 0; k < NEL; k++)
            pr_basis[k] = ((k % (DIM + 1)) == 0) ? lsqu_pkg::Q_ONE : 32'sd0;
        for (int c = 0; c < DIM; c++) pr_expo[c] = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: extreme entries at the default step, then zero matrix
        for (int k = 0; k < NEL; k++) begin
            case (k % 3)
                0: push_jac(lsqu_pkg::S32_MAX);
                1: push_jac(lsqu_pkg::S32_MIN);
                default: push_jac(32'sd0);
            endcase
        end
        wait_drained();
        write_step(31'd1);
        for (int k = 0; k < NEL; k++) push_jac(32'sd0);
        wait_drained();

        // Random phases with varied step settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: ts = 31'h7FFF_FFFF;
                1: ts = 31'd1;
                2: ts = 31'($urandom_range(1, 32'h7FFF_FFFF));
                default: ts = 31'($urandom_range(1, 32'h0100_0000));
            endcase
            write_step(ts);
            idle_en = (ph != 3);
            push_random_matrix();
            wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0 && spectrum_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lsqu_pkg.sv
rtl/core/lyapunov_spectrum_qr_update_unit.sv
verif/lyapunov_spectrum_qr_update_unit_test.sv
